// ===== design/lnefm_pkg.sv =====
package lnefm_pkg;

  // Field widths of one item.
  localparam int TIME_W      = 32;
  localparam int RATE_W      = 48;
  localparam int PERIOD_W    = 40;
  localparam int RATE_FRAC   = 32;
  localparam int PERIOD_FRAC = 8;

  // Output stream packing: rate, then period, which together fill whole bytes.
  localparam int OUT_DATA_W  = 88;

  typedef logic [TIME_W-1:0]   stamp_t;
  typedef logic [RATE_W-1:0]   rate_t;
  typedef logic [PERIOD_W-1:0] period_t;

endpackage

// ===== design/last_n_events_frequency_meter_core.sv =====
// An accepted input item goes through the load state, DIV_N division steps and the
// done state, which waits for a free output, before m_tvalid is set. DIV_N is
// max(40, 32 + clog2(WINDOW)), the length of the bit-serial division in two restoring
// dividers that retire one quotient bit per cycle side by side; new items wait for idle.
// Reset clears the write pointer, the ring fill flag and the output valid; the
// timestamp ring itself is not cleared, and entries never written read as zero.
module last_n_events_frequency_meter_core #(
  parameter int WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] event_time
  input  logic [lnefm_pkg::TIME_W-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [47:0] rate_fixed, [87:48] period_fixed
  output logic [lnefm_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [0] zero_span
  output logic [0:0]                        m_tuser
);

  localparam int SLOT_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int GAP_W   = SLOT_W;
  localparam int RATE_DW = lnefm_pkg::TIME_W + GAP_W;
  localparam int DIV_N   = (RATE_DW > lnefm_pkg::PERIOD_W) ? RATE_DW : lnefm_pkg::PERIOD_W;
  localparam int CNT_W   = $clog2(DIV_N);
  localparam int T_W     = lnefm_pkg::TIME_W;

  localparam logic [GAP_W-1:0]  GAPS      = GAP_W'(WINDOW - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DIV_N - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state;
  logic [SLOT_W-1:0]       slot;
  logic                    full;
  logic                    oldest_valid;
  lnefm_pkg::stamp_t       ring [WINDOW];
  lnefm_pkg::stamp_t       oldest;
  lnefm_pkg::stamp_t       newest;
  lnefm_pkg::stamp_t       span;
  lnefm_pkg::stamp_t       divisor;
  logic                    zero;
  logic [CNT_W-1:0]        cnt;

  logic [DIV_N-1:0]        rate_d;
  lnefm_pkg::stamp_t       rate_r;
  logic [T_W:0]            rate_shift;
  logic [T_W:0]            rate_diff;
  logic [DIV_N-1:0]        per_d;
  logic [GAP_W-1:0]        per_r;
  logic [GAP_W:0]          per_shift;
  logic [GAP_W:0]          per_diff;

  logic [SLOT_W-1:0]       slot_next;
  logic                    in_accept;
  logic                    out_free;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign slot_next = (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);

  // The oldest entry is the one after the slot just written. It holds real
  // data once the ring has wrapped, or when it is slot zero (always written first).
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring[slot] <= s_tdata;
      oldest     <= ring[slot_next];
      newest     <= s_tdata;
    end
  end

  assign span = newest - (oldest_valid ? oldest : '0);

  // One restoring step per cycle in each divider.
  assign rate_shift = {rate_r, rate_d[DIV_N-1]};
  assign rate_diff  = rate_shift - {1'b0, divisor};
  assign per_shift  = {per_r, per_d[DIV_N-1]};
  assign per_diff   = per_shift - {1'b0, GAPS};

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        divisor <= span;
        zero    <= (span == '0);
        rate_d  <= DIV_N'(GAPS) << lnefm_pkg::RATE_FRAC;
        rate_r  <= '0;
        per_d   <= DIV_N'(span) << lnefm_pkg::PERIOD_FRAC;
        per_r   <= '0;
      end
      ST_DIV: begin
        if (!rate_diff[T_W]) begin
          rate_r <= rate_diff[T_W-1:0];
          rate_d <= {rate_d[DIV_N-2:0], 1'b1};
        end else begin
          rate_r <= rate_shift[T_W-1:0];
          rate_d <= {rate_d[DIV_N-2:0], 1'b0};
        end
        if (!per_diff[GAP_W]) begin
          per_r <= per_diff[GAP_W-1:0];
          per_d <= {per_d[DIV_N-2:0], 1'b1};
        end else begin
          per_r <= per_shift[GAP_W-1:0];
          per_d <= {per_d[DIV_N-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata[lnefm_pkg::RATE_W-1:0] <= zero ? '1 : lnefm_pkg::RATE_W'(rate_d);
      m_tdata[lnefm_pkg::OUT_DATA_W-1:lnefm_pkg::RATE_W] <=
        (lnefm_pkg::OUT_DATA_W - lnefm_pkg::RATE_W)'(lnefm_pkg::PERIOD_W'(per_d));
      m_tuser <= zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot         <= '0;
      full         <= 1'b0;
      oldest_valid <= 1'b0;
      cnt          <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // In the done state the valid is set below whenever the output is free.
      if (m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            oldest_valid <= full || (slot == SLOT_LAST);
            if (slot == SLOT_LAST) begin
              full <= 1'b1;
            end
            slot  <= slot_next;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_LOAD)
    else $error("accepted item did not start the ring read");

  a_zero_span_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[lnefm_pkg::RATE_W-1:0] == '1 &&
      m_tdata[lnefm_pkg::RATE_W+lnefm_pkg::PERIOD_W-1:lnefm_pkg::RATE_W] == '0)
    else $error("zero span result not saturated");

  a_full_sticks: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("ring fill flag dropped");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && m_tvalid && !m_tready |=> state == ST_DONE)
    else $error("finished result overran a pending output item");

endmodule
